FILE: design/wsfe_pkg.sv
// Shared types, widths and constants of the WebSocket frame encoder.
package wsfe_pkg;

    localparam int OPC_W  = 4;
    localparam int LEN_W  = 17;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 32;
    localparam int KEY_W  = 32;

    // Request kinds on the input channel
    typedef enum logic {
        REQ_START = 1'b0,
        REQ_BYTE  = 1'b1
    } t_req;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_NO_ROOM  = 2'd2,
        ST_NO_FRAME = 2'd3
    } t_status;

    localparam logic [BYTE_W-1:0] FIN_BIT   = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_BIT  = 8'h80;
    localparam logic [6:0]        LEN_EXT16 = 7'd126;
    localparam logic [3:0]        HDR_SHORT = 4'd6;
    localparam logic [3:0]        HDR_LONG  = 4'd8;

endpackage

FILE: design/wsfe_in_if.sv
// Request channel: frame start or payload byte, valid/ready handshake.
interface wsfe_in_if;
    logic                              valid;
    logic                              ready;
    wsfe_pkg::t_req                    req_type;
    logic [wsfe_pkg::OPC_W-1:0]        frame_opcode;
    logic [wsfe_pkg::LEN_W-1:0]        frame_len;
    logic [wsfe_pkg::LEN_W-1:0]        out_capacity;
    logic [wsfe_pkg::BYTE_W-1:0]       payload_byte;

    modport source (
        output valid, req_type, frame_opcode, frame_len, out_capacity, payload_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, frame_opcode, frame_len, out_capacity, payload_byte,
        output ready
    );
endinterface

FILE: design/wsfe_out_if.sv
// Result channel: emitted frame byte with status, valid/ready handshake.
interface wsfe_out_if;
    logic                              valid;
    logic                              ready;
    logic [wsfe_pkg::BYTE_W-1:0]       out_byte;
    logic                              item_last;
    logic                              frame_end;
    wsfe_pkg::t_status                 status;
    logic [wsfe_pkg::CNT_W-1:0]        sent_total;

    modport source (
        output valid, out_byte, item_last, frame_end, status, sent_total,
        input  ready
    );
    modport sink (
        input  valid, out_byte, item_last, frame_end, status, sent_total,
        output ready
    );
endinterface

FILE: design/websocket_frame_encoder.sv
// Client-side WebSocket frame encoder: header builder and payload masker.
//
// A start beat produces the frame header one byte per cycle while the sink
// takes results: 6 bytes for a payload under 126 bytes, 8 bytes with the
// 16-bit extended length, or a single error result when the length is 65536
// or more or the frame does not fit the given capacity. A payload beat
// produces one masked byte, so payload streams at one beat per clock while
// the sink takes each result. The one result register carries one byte at
// a time, while the item register holds the start beat and steps a header
// byte index. The next request is taken in the cycle its predecessor's last
// result is loaded, and a result waiting in the output register does not
// block that load once the sink takes it. The user must write the mask key
// through i_cfg_we / i_cfg_wdata while the block is idle (not enforced).
module websocket_frame_encoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wsfe_pkg::KEY_W-1:0]     i_cfg_wdata,
    wsfe_in_if.sink                        i_req,
    wsfe_out_if.source                     o_res
);

    // Item register
    logic                              r_s1_valid;
    wsfe_pkg::t_req                    r_s1_req;
    logic [wsfe_pkg::OPC_W-1:0]        r_s1_opc;
    logic [wsfe_pkg::LEN_W-1:0]        r_s1_len;
    logic [wsfe_pkg::LEN_W-1:0]        r_s1_cap;
    logic [wsfe_pkg::BYTE_W-1:0]       r_s1_pb;
    logic [2:0]                        r_idx;

    // Frame state
    logic [wsfe_pkg::KEY_W-1:0]        r_mask_key;
    logic                              r_open;
    logic [15:0]                       r_left;
    logic [1:0]                        r_phase;
    logic [wsfe_pkg::CNT_W-1:0]        r_sent;

    // Result register
    logic                              r_out_valid;
    logic [wsfe_pkg::BYTE_W-1:0]       r_out_byte;
    logic                              r_out_last;
    logic                              r_out_fend;
    wsfe_pkg::t_status                 r_out_status;
    logic [wsfe_pkg::CNT_W-1:0]        r_out_sent;

    // Next values
    logic                              n_open;
    logic [15:0]                       n_left;
    logic [1:0]                        n_phase;
    logic [wsfe_pkg::CNT_W-1:0]        n_sent;

    logic                              w_load;
    logic                              w_accept;
    logic                              w_item_done;
    logic                              w_long;
    logic                              w_too_long;
    logic                              w_no_room;
    logic [2:0]                        w_last_idx;
    logic [wsfe_pkg::LEN_W:0]          w_frame_total;
    logic [1:0]                        w_key_sel;
    logic [wsfe_pkg::BYTE_W-1:0]       w_key_byte;
    logic [wsfe_pkg::BYTE_W-1:0]       w_hdr_byte;
    logic [wsfe_pkg::BYTE_W-1:0]       w_byte;
    logic                              w_last;
    logic                              w_fend;
    wsfe_pkg::t_status                 w_status;

    // Handshake
    assign w_load      = r_s1_valid && (!r_out_valid || o_res.ready);
    assign w_item_done = w_load && w_last;
    assign i_req.ready = !r_s1_valid || w_item_done;
    assign w_accept    = i_req.valid && i_req.ready;

    // Frame checks on the held start beat
    assign w_long        = (r_s1_len >= {10'd0, wsfe_pkg::LEN_EXT16});
    assign w_too_long    = r_s1_len[wsfe_pkg::LEN_W-1];
    assign w_frame_total = {1'b0, r_s1_len}
                         + {{(wsfe_pkg::LEN_W-3){1'b0}},
                            (w_long ? wsfe_pkg::HDR_LONG : wsfe_pkg::HDR_SHORT)};
    assign w_no_room     = (w_frame_total > {1'b0, r_s1_cap});
    assign w_last_idx    = w_long ? 3'd7 : 3'd5;

    // Pick a key byte, most significant first
    always_comb begin
        if (r_s1_req == wsfe_pkg::REQ_BYTE) begin
            w_key_sel = r_phase;
        end else if (w_long) begin
            w_key_sel = r_idx[1:0];
        end else begin
            w_key_sel = r_idx[1:0] - 2'd2;
        end
        case (w_key_sel)
            2'd0:    w_key_byte = r_mask_key[31:24];
            2'd1:    w_key_byte = r_mask_key[23:16];
            2'd2:    w_key_byte = r_mask_key[15:8];
            default: w_key_byte = r_mask_key[7:0];
        endcase
    end

    // Header byte at the current index
    always_comb begin
        case (r_idx)
            3'd0:    w_hdr_byte = wsfe_pkg::FIN_BIT | {4'd0, r_s1_opc};
            3'd1:    w_hdr_byte = w_long ? (wsfe_pkg::MASK_BIT | {1'b0, wsfe_pkg::LEN_EXT16})
                                         : (wsfe_pkg::MASK_BIT | {1'b0, r_s1_len[6:0]});
            3'd2:    w_hdr_byte = w_long ? r_s1_len[15:8] : w_key_byte;
            3'd3:    w_hdr_byte = w_long ? r_s1_len[7:0]  : w_key_byte;
            default: w_hdr_byte = w_key_byte;
        endcase
    end

    // Result and next frame state for the held beat
    always_comb begin
        w_byte   = '0;
        w_last   = 1'b1;
        w_fend   = 1'b0;
        w_status = wsfe_pkg::ST_OK;
        n_open   = r_open;
        n_left   = r_left;
        n_phase  = r_phase;
        n_sent   = r_sent;
        if (r_s1_req == wsfe_pkg::REQ_START) begin
            if (w_too_long) begin
                w_status = wsfe_pkg::ST_TOO_LONG;
                n_open   = 1'b0;
            end else if (w_no_room) begin
                w_status = wsfe_pkg::ST_NO_ROOM;
                n_open   = 1'b0;
            end else begin
                w_byte = w_hdr_byte;
                w_last = (r_idx == w_last_idx);
                w_fend = w_last && (r_s1_len[15:0] == 16'd0);
                n_sent = r_sent + 32'd1;
                if (w_last) begin
                    n_open  = (r_s1_len[15:0] != 16'd0);
                    n_left  = r_s1_len[15:0];
                    n_phase = 2'd0;
                end
            end
        end else if (!r_open) begin
            w_status = wsfe_pkg::ST_NO_FRAME;
        end else begin
            w_byte  = r_s1_pb ^ w_key_byte;
            n_left  = r_left - 16'd1;
            w_fend  = (n_left == 16'd0);
            n_open  = !w_fend;
            n_phase = r_phase + 2'd1;
            n_sent  = r_sent + 32'd1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_idx       <= '0;
            r_mask_key  <= '0;
            r_open      <= 1'b0;
            r_left      <= '0;
            r_phase     <= '0;
            r_sent      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask_key <= i_cfg_wdata;
            end
            // Advance the item register
            if (w_accept) begin
                r_s1_valid <= 1'b1;
                r_idx      <= '0;
            end else if (w_item_done) begin
                r_s1_valid <= 1'b0;
            end else if (w_load) begin
                r_idx <= r_idx + 3'd1;
            end
            // Commit frame state with each result
            if (w_load) begin
                r_open  <= n_open;
                r_left  <= n_left;
                r_phase <= n_phase;
                r_sent  <= n_sent;
            end
            // Hold or drop the result beat
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_req <= i_req.req_type;
            r_s1_opc <= i_req.frame_opcode;
            r_s1_len <= i_req.frame_len;
            r_s1_cap <= i_req.out_capacity;
            r_s1_pb  <= i_req.payload_byte;
        end
        if (w_load) begin
            r_out_byte   <= w_byte;
            r_out_last   <= w_last;
            r_out_fend   <= w_fend;
            r_out_status <= w_status;
            r_out_sent   <= n_sent;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.out_byte   = r_out_byte;
    assign o_res.item_last  = r_out_last;
    assign o_res.frame_end  = r_out_fend;
    assign o_res.status     = r_out_status;
    assign o_res.sent_total = r_out_sent;

`ifndef NO_ASSERTIONS
    // Error results are single, empty and never close a frame on the wire
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != wsfe_pkg::ST_OK)
        |-> (r_out_last && !r_out_fend && r_out_byte == '0))
        else $error("error result with data, frame end or not last");

    // Frame end only on the last result of a beat
    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fend) |-> r_out_last)
        else $error("frame end on a result that is not last");

    // Every good result advances the byte count by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_status == wsfe_pkg::ST_OK)
        |=> (r_sent == $past(r_sent) + 32'd1))
        else $error("byte count did not advance on a good result");

    // A short header never steps past its sixth byte
    a_short_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_req == wsfe_pkg::REQ_START && !w_long) |-> (r_idx < 3'd6))
        else $error("short header index out of range");

    // An empty item register always takes a request
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_req.ready)
        else $error("request stalled with an empty item register");
`endif

endmodule
